FILE: hw/rtl/ppp_pkg.sv
package ppp_pkg;

  localparam int DATA_W   = 32;
  localparam int PROD_W   = 64;
  localparam int NDC_W    = 48;
  localparam int DIM_W    = 14;
  localparam int IDX_W    = 4;
  localparam int QUOT_W   = 62;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_PROJECT = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MAC,
    OP_CHECK,
    OP_DIV,
    OP_MAP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] row;
    logic [1:0] col;
    logic       start;
    logic       axis;
  } dp_cmd_t;

  typedef struct packed {
    logic visible;
    logic div_done;
  } dp_status_t;

endpackage

FILE: hw/rtl/ppp_ctrl.sv
module ppp_ctrl
  import ppp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_stall,
  input  logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       load_en,
  output logic       out_set
);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_CHECK, S_DIV_START, S_DIV, S_MAP, S_DONE
  } state_t;

  state_t     state_r;
  logic [1:0] row_r;
  logic [1:0] col_r;
  logic       axis_r;

  logic take;

  assign in_stall = (state_r != S_IDLE) || (out_valid && out_stall);
  assign take     = in_valid && !in_stall;
  assign load_en  = take && (in_kind == KIND_LOAD);

  always_comb begin
    cmd       = '0;
    cmd.op    = OP_IDLE;
    cmd.row   = row_r;
    cmd.col   = col_r;
    cmd.axis  = axis_r;
    out_set   = 1'b0;
    unique case (state_r)
      S_IDLE:      cmd.op = OP_IDLE;
      S_MAC:       cmd.op = OP_MAC;
      S_CHECK:     cmd.op = OP_CHECK;
      S_DIV_START: begin
        cmd.op    = OP_DIV;
        cmd.start = 1'b1;
      end
      S_DIV:       cmd.op = OP_DIV;
      S_MAP:       cmd.op = OP_MAP;
      S_DONE:      out_set = 1'b1;
      default:     cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      axis_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (take && in_kind == KIND_PROJECT) begin
            state_r <= S_MAC;
            row_r   <= '0;
            col_r   <= '0;
          end
        end
        S_MAC: begin
          col_r <= col_r + 2'd1;
          if (col_r == 2'd3) begin
            if (row_r == 2'd2) begin
              state_r <= S_CHECK;
            end else begin
              row_r <= row_r + 2'd1;
            end
          end
        end
        S_CHECK: begin
          axis_r  <= 1'b0;
          state_r <= status.visible ? S_DIV_START : S_DONE;
        end
        S_DIV_START: state_r <= S_DIV;
        S_DIV: begin
          if (status.div_done) begin
            state_r <= S_MAP;
          end
        end
        S_MAP: begin
          if (axis_r) begin
            state_r <= S_DONE;
          end else begin
            axis_r  <= 1'b1;
            state_r <= S_DIV_START;
          end
        end
        S_DONE:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ppp_datapath.sv
module ppp_datapath
  import ppp_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  input  logic                     take,
  input  logic                     load_en,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [DATA_W-1:0] element_value,
  input  logic signed [DATA_W-1:0] point_x,
  input  logic signed [DATA_W-1:0] point_y,
  input  logic signed [DATA_W-1:0] point_z,
  input  logic [DIM_W-1:0]         width,
  input  logic [DIM_W-1:0]         height,
  output dp_status_t               status,
  output logic signed [DATA_W-1:0] res_x,
  output logic signed [DATA_W-1:0] res_y
);

  // A clip value holds three full products shifted by the fraction plus a
  // translation element.
  localparam int CLIP_W = 2*DATA_W - FRAC_BITS + 1;
  localparam int DIVW  = 64 + FRAC_BITS;
  localparam int CNT_W = $clog2(DIVW + 1);
  localparam logic [NDC_W-1:0] NDC_CAP = NDC_W'(64'd1 << 46);

  logic signed [DATA_W-1:0] mat_r [16];
  logic signed [DATA_W-1:0] px_r, py_r, pz_r;
  logic signed [CLIP_W-1:0] clip_r [3];
  logic vis_now;

  logic signed [DATA_W-1:0] mult_a;
  logic signed [DATA_W-1:0] mult_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [CLIP_W-1:0] term;
  logic [3:0]               mat_idx;
  logic [1:0]               clip_sel;

  always_comb begin
    clip_sel = (cmd.row == 2'd2) ? 2'd2 : cmd.row;
    mat_idx  = {cmd.col, (cmd.row == 2'd2) ? 2'd3 : cmd.row};
    unique case (cmd.col)
      2'd0:    mult_a = px_r;
      2'd1:    mult_a = py_r;
      2'd2:    mult_a = pz_r;
      default: mult_a = '0;
    endcase
    mult_b = mat_r[mat_idx];
    prod   = mult_a * mult_b;
    if (cmd.col == 2'd3) begin
      term = CLIP_W'(mult_b);
    end else begin
      term = CLIP_W'(prod >>> FRAC_BITS);
    end
  end

  logic signed [CLIP_W+4-1:0] w10;
  assign w10 = (CLIP_W+4)'(clip_r[2]) * 10;
  // Clip w stays put from the check until the next item is taken.
  assign vis_now = !(w10 < (CLIP_W+4)'(64'sd1 <<< FRAC_BITS));

  // Serial restoring divider.
  logic [DIVW-1:0]    dividend_r;
  logic [CLIP_W-1:0]  rem_r;
  logic [QUOT_W-1:0]  quot_r;
  logic               over_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               neg_r;
  logic [CLIP_W:0]    rem_sh;
  logic signed [CLIP_W-1:0] num;
  logic [CLIP_W-1:0]  mag;

  assign num    = cmd.axis ? clip_r[1] : clip_r[0];
  assign mag    = num[CLIP_W-1] ? CLIP_W'(-num) : CLIP_W'(num);
  assign rem_sh = {rem_r, dividend_r[DIVW-1]};

  logic signed [NDC_W-1:0] ndc;
  logic [NDC_W-1:0]        qcap;
  always_comb begin
    if (over_r || quot_r > QUOT_W'(NDC_CAP)) begin
      qcap = NDC_CAP;
    end else begin
      qcap = NDC_W'(quot_r);
    end
    ndc = neg_r ? -$signed(qcap) : $signed(qcap);
  end

  logic signed [NDC_W-1:0] ndc_r;
  logic [DIM_W-1:0]        dim;
  logic signed [NDC_W+DIM_W:0] scaled;
  logic signed [NDC_W+DIM_W+1:0] sum;
  logic signed [NDC_W+DIM_W+1:0] half;
  logic signed [DATA_W-1:0]  sat;

  localparam logic signed [NDC_W+DIM_W+1:0] SMAX = (NDC_W+DIM_W+2)'(64'sd2147483647);
  localparam logic signed [NDC_W+DIM_W+1:0] SMIN = -(NDC_W+DIM_W+2)'(64'sd2147483648);

  assign dim    = cmd.axis ? height : width;
  assign scaled = ndc_r * $signed({1'b0, dim});
  always_comb begin
    if (cmd.axis) begin
      sum = ((NDC_W+DIM_W+2)'(dim) <<< FRAC_BITS) - (NDC_W+DIM_W+2)'(scaled);
    end else begin
      sum = ((NDC_W+DIM_W+2)'(dim) <<< FRAC_BITS) + (NDC_W+DIM_W+2)'(scaled);
    end
    half = sum >>> 1;
    if (half > SMAX) begin
      sat = DATA_W'(SMAX);
    end else if (half < SMIN) begin
      sat = DATA_W'(SMIN);
    end else begin
      sat = DATA_W'(half);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      px_r <= point_x;
      py_r <= point_y;
      pz_r <= point_z;
      clip_r[0] <= '0;
      clip_r[1] <= '0;
      clip_r[2] <= '0;
    end
    if (cmd.op == OP_MAC) begin
      clip_r[clip_sel] <= clip_r[clip_sel] + term;
    end
    if (cmd.op == OP_CHECK) begin
      res_x <= '0;
      res_y <= '0;
    end
    if (cmd.op == OP_DIV && cmd.start) begin
      dividend_r <= {{(DIVW-CLIP_W){1'b0}}, mag} << FRAC_BITS;
      neg_r      <= num[CLIP_W-1];
      rem_r      <= '0;
      quot_r     <= '0;
      over_r     <= 1'b0;
    end else if (busy_r) begin
      dividend_r <= dividend_r << 1;
      if (quot_r[QUOT_W-1]) begin
        over_r <= 1'b1;
      end
      if (rem_sh >= {1'b0, clip_r[2]}) begin
        rem_r  <= CLIP_W'(rem_sh - {1'b0, clip_r[2]});
        quot_r <= {quot_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[CLIP_W-1:0];
        quot_r <= {quot_r[QUOT_W-2:0], 1'b0};
      end
    end
    if (cmd.op == OP_DIV && status.div_done) begin
      ndc_r <= ndc;
    end
    if (cmd.op == OP_MAP) begin
      if (cmd.axis) begin
        res_y <= (height == '0) ? '0 : sat;
      end else begin
        res_x <= (width == '0) ? '0 : sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= '0;
      end
    end else begin
      if (cmd.op == OP_DIV && cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
      if (load_en) begin
        mat_r[element_index] <= element_value;
      end
    end
  end

  assign status.visible  = vis_now;
  assign status.div_done = !busy_r && !cmd.start;

endmodule

FILE: hw/rtl/perspective_point_projector.sv
// Perspective point projector.
// Input channel: in_valid/in_stall with in_kind, a matrix element (load) or a
// world point (project). A transfer happens at a clock edge with valid high
// and stall low. A load writes one Q16.16 matrix element and gives no result.
// A project transfer gives exactly one result on the out_ channel: visible
// flag plus screen_x and screen_y in Q16.16, saturated to 32 bits.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 (width) and 1 (height);
// cfg_ready is always high and other indexes are ignored.
// Work: a project item runs multiply-accumulate steps on one shared
// 32x32 multiplier and a visibility check, then for each axis a start
// step, a bit-serial divider, a finish step and a mapping step, and last
// a step that loads the result register and raises out_valid.
// Invisible points skip the division and mapping.
// Only one item is worked on at a time; the next one can be taken while
// the result is presented, unless the receiver stalls. Loads are taken
// back to back while the block is idle and the output is not stalled.
// Reset clears the matrix to zero and sets the viewport to 1920 by 1080.
// When the receiver stalls, the result register holds and the input stalls
// until the result transfer has taken place.
module perspective_point_projector
  import ppp_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic [IDX_W-1:0]         in_element_index,
  input  logic signed [DATA_W-1:0] in_element_value,
  input  logic signed [DATA_W-1:0] in_point_x,
  input  logic signed [DATA_W-1:0] in_point_y,
  input  logic signed [DATA_W-1:0] in_point_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_visible,
  output logic signed [DATA_W-1:0] out_screen_x,
  output logic signed [DATA_W-1:0] out_screen_y,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       load_en;
  logic       out_set;
  logic       take;
  logic [DIM_W-1:0] width_r, height_r;
  logic signed [DATA_W-1:0] res_x, res_y;
  logic out_valid_r;

  assign cfg_ready = 1'b1;
  assign take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1920);
      height_r <= DIM_W'(1080);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    width_r  <= width_r;
      endcase
    end
  end

  ppp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid_r),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .load_en   (load_en),
    .out_set   (out_set)
  );

  ppp_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .take          (take),
    .load_en       (load_en),
    .element_index (in_element_index),
    .element_value (in_element_value),
    .point_x       (in_point_x),
    .point_y       (in_point_y),
    .point_z       (in_point_z),
    .width         (width_r),
    .height        (height_r),
    .status        (status),
    .res_x         (res_x),
    .res_y         (res_y)
  );

  // The result register holds until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_set) begin
      out_valid_r  <= 1'b1;
      out_visible  <= status.visible;
      out_screen_x <= res_x;
      out_screen_y <= res_y;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: dv/tb_perspective_point_projector.sv
`timescale 1ns / 1ps

module tb_perspective_point_projector;
  import ppp_pkg::*;

  localparam int FRAC = 16;
  localparam longint NDC_LIMIT = 64'd1 << 46;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  // The limit leaves room for the slowest legal run, with the stalls, the
  // long receiver hold-off and the drain waits.
  localparam int CYCLE_LIMIT = 3000000;
  // This wait is longer than a projection, so it covers any work in flight.
  localparam int DRAIN_CYCLES = 300;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_kind;
  logic [IDX_W-1:0] in_element_index;
  logic signed [DATA_W-1:0] in_element_value;
  logic signed [DATA_W-1:0] in_point_x;
  logic signed [DATA_W-1:0] in_point_y;
  logic signed [DATA_W-1:0] in_point_z;
  logic out_valid;
  logic out_stall;
  logic out_visible;
  logic signed [DATA_W-1:0] out_screen_x;
  logic signed [DATA_W-1:0] out_screen_y;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [DIM_W-1:0] cfg_data;

  perspective_point_projector dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_element_index(in_element_index),
    .in_element_value(in_element_value),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_point_z(in_point_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_visible(out_visible),
    .out_screen_x(out_screen_x),
    .out_screen_y(out_screen_y),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // One pixel result as the block should produce it.
  typedef struct {
    logic visible;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } pixel_t;

  // One input item, plus an optional hand-typed expectation for the
  // directed rows whose answer is obvious.
  typedef struct {
    logic kind;
    logic [3:0] idx;
    logic signed [31:0] val;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    bit typed;
    pixel_t res;
  } stim_row_t;

  // Shadow state: the matrix and viewport as the block should hold them.
  logic signed [31:0] shadow_mat [16];
  longint view_w;
  longint view_h;

  pixel_t pending_pixels [$];
  stim_row_t dir_tab [$];
  int errors;
  int tx_idle;
  int rx_idle;
  logic rx_hold;
  int cycles;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[perspective_point_projector] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // One row of the transform: three products, each floored after the
  // fraction shift, plus the translation element taken as it is.
  function automatic longint clip_row(int r, longint x, longint y, longint z);
    longint a;
    longint b;
    longint c;
    a = longint'(shadow_mat[r]);
    b = longint'(shadow_mat[r + 4]);
    c = longint'(shadow_mat[r + 8]);
    return ((x * a) >>> FRAC) + ((y * b) >>> FRAC) + ((z * c) >>> FRAC)
           + longint'(shadow_mat[r + 12]);
  endfunction

  // Normalized coordinate: (clip << FRAC) / w truncated toward zero, with
  // the magnitude capped so that the mapping always saturates beyond it.
  function automatic longint ndc_div(longint c, longint w);
    logic [127:0] num;
    logic [127:0] quo;
    logic [63:0] mag;
    mag = (c < 0) ? -c : c;
    num = {64'd0, mag} << FRAC;
    quo = num / {64'd0, w};
    if (quo > NDC_LIMIT)
      quo = NDC_LIMIT;
    return (c < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic longint sat32(longint v);
    if (v > S32_HI)
      return S32_HI;
    if (v < S32_LO)
      return S32_LO;
    return v;
  endfunction

  function automatic pixel_t project_point(longint x, longint y, longint z);
    pixel_t p;
    longint cx;
    longint cy;
    longint cw;
    cx = clip_row(0, x, y, z);
    cy = clip_row(1, x, y, z);
    cw = clip_row(3, x, y, z);
    p.visible = 1'b0;
    p.sx = '0;
    p.sy = '0;
    // Visibility is an exact compare against 0.1 in fixed point.
    if (cw * 10 >= (64'sd1 <<< FRAC)) begin
      p.visible = 1'b1;
      p.sx = 32'(sat32(((view_w <<< FRAC) + ndc_div(cx, cw) * view_w) >>> 1));
      p.sy = 32'(sat32(((view_h <<< FRAC) - ndc_div(cy, cw) * view_h) >>> 1));
    end
    return p;
  endfunction

  // Drive one item and hold it until the block takes it. Idle cycles in
  // front of the item are drawn per cycle so gaps land on every phase of
  // the block's work.
  task automatic send_item(stim_row_t row);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_kind <= row.kind;
    in_element_index <= row.idx;
    in_element_value <= row.val;
    in_point_x <= row.px;
    in_point_y <= row.py;
    in_point_z <= row.pz;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    // The transfer happened at this edge; update the shadow state or
    // record what the result should be.
    if (row.kind == KIND_LOAD)
      shadow_mat[row.idx] = row.val;
    else if (row.typed)
      pending_pixels.push_back(row.res);
    else
      pending_pixels.push_back(project_point(longint'(row.px), longint'(row.py),
                                             longint'(row.pz)));
  endtask

  // Let every result come out, then give a load in flight time to finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_reg(logic idx, logic [DIM_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH)
      view_w = longint'(data);
    else
      view_h = longint'(data);
  endtask

  task automatic add_row(logic kind, logic [3:0] idx, logic signed [31:0] val,
                         logic signed [31:0] px, logic signed [31:0] py,
                         logic signed [31:0] pz, bit typed, logic vis,
                         logic signed [31:0] sx, logic signed [31:0] sy);
    stim_row_t r;
    r.kind = kind;
    r.idx = idx;
    r.val = val;
    r.px = px;
    r.py = py;
    r.pz = pz;
    r.typed = typed;
    r.res.visible = vis;
    r.res.sx = sx;
    r.res.sy = sy;
    dir_tab.push_back(r);
  endtask

  function automatic logic signed [31:0] small_fix(int span_bits);
    return $signed($urandom_range(0, (1 << span_bits) - 1)) - (1 << (span_bits - 1));
  endfunction

  // Random item. Most traffic keeps clip w positive and the values modest
  // so that the division and mapping paths are exercised; the rest is
  // full-range noise, including points behind the camera.
  function automatic stim_row_t random_row();
    stim_row_t r;
    int pick;
    pick = $urandom_range(99);
    r.typed = 1'b0;
    r.idx = 4'($urandom);
    r.val = $urandom;
    r.px = $urandom;
    r.py = $urandom;
    r.pz = $urandom;
    if (pick < 10) begin
      // Translation of clip w, sometimes right at the visibility threshold.
      r.kind = KIND_LOAD;
      r.idx = 4'd15;
      r.val = ($urandom_range(3) == 0) ? $urandom_range(6540, 6570)
                                       : $urandom_range(6000, 655360);
    end else if (pick < 30) begin
      r.kind = KIND_LOAD;
      r.val = small_fix(19);
    end else if (pick < 34) begin
      r.kind = KIND_LOAD;
    end else begin
      r.kind = KIND_PROJECT;
      if ($urandom_range(99) < 80) begin
        r.px = small_fix(24);
        r.py = small_fix(24);
        r.pz = small_fix(24);
      end
    end
    return r;
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_item(random_row());
  endtask

  // Result side: compare each transfer with the oldest expectation and
  // choose the stall for the next cycle.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("unexpected result", longint'(out_screen_x), 0);
        end else begin
          want = pending_pixels.pop_front();
          if (out_visible !== want.visible)
            report_mismatch("visible", longint'(out_visible), longint'(want.visible));
          if (out_screen_x !== want.sx)
            report_mismatch("screen_x", longint'(out_screen_x), longint'(want.sx));
          if (out_screen_y !== want.sy)
            report_mismatch("screen_y", longint'(out_screen_y), longint'(want.sy));
        end
      end
      out_stall <= rx_hold || ($urandom_range(99) < rx_idle);
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    tx_idle = 0;
    rx_idle = 0;
    rx_hold = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_LOAD;
    in_element_index = '0;
    in_element_value = '0;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    for (int i = 0; i < 16; i++)
      shadow_mat[i] = '0;
    view_w = 1920;
    view_h = 1080;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. After reset the matrix is zero, so clip w is zero and
    // the point is not visible.
    add_row(KIND_PROJECT, 4'hF, 32'h7FFFFFFF, 32'h00010000, 32'h00020000, 32'h00030000,
            1, 0, 0, 0);
    // Identity on x and y, clip w fixed at one. Point fields on loads are junk.
    add_row(KIND_LOAD, 4'd15, 32'h00010000, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
            0, 0, 0, 0);
    add_row(KIND_LOAD, 4'd0, 32'h00010000, 32'h12345678, 32'h0, 32'h0, 0, 0, 0, 0);
    add_row(KIND_LOAD, 4'd5, 32'h00010000, 32'h0, 32'hDEADBEEF, 32'h0, 0, 0, 0, 0);
    // The origin lands on the center of the default viewport.
    add_row(KIND_PROJECT, 4'd7, 32'h80000000, 32'h0, 32'h0, 32'h0,
            1, 1, 32'h03C00000, 32'h021C0000);
    // Extreme points saturate the pixel output in both directions.
    add_row(KIND_PROJECT, 4'd0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h0,
            1, 1, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_row(KIND_PROJECT, 4'd0, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'h0,
            1, 1, 32'h80000000, 32'h80000000);
    add_row(KIND_PROJECT, 4'd0, 32'h0, 32'h00018000, 32'hFFFF4000, 32'h7FFFFFFF,
            0, 0, 0, 0);
    // Clip w one step below 0.1 is not visible; one step above is.
    add_row(KIND_LOAD, 4'd15, 32'd6553, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0);
    add_row(KIND_PROJECT, 4'd0, 32'h0, 32'h00001000, 32'h00002000, 32'h0, 1, 0, 0, 0);
    add_row(KIND_LOAD, 4'd15, 32'd6554, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0);
    add_row(KIND_PROJECT, 4'd0, 32'h0, 32'h00001000, 32'hFFFFE000, 32'h0, 0, 0, 0, 0);
    // A negative clip w means the point is behind the camera.
    add_row(KIND_LOAD, 4'd15, 32'h80000000, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0);
    add_row(KIND_PROJECT, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1, 0, 0, 0);
    // Full-scale elements on the x row, with w driven by z.
    add_row(KIND_LOAD, 4'd4, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0);
    add_row(KIND_LOAD, 4'd8, 32'h80000000, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0);
    add_row(KIND_LOAD, 4'd11, 32'h00010000, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0);
    add_row(KIND_LOAD, 4'd15, 32'h00020000, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0);
    add_row(KIND_PROJECT, 4'd0, 32'h0, 32'h00030000, 32'h00000001, 32'h00050000,
            0, 0, 0, 0);
    add_row(KIND_PROJECT, 4'd0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            0, 0, 0, 0);
    add_row(KIND_PROJECT, 4'd0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00001000,
            0, 0, 0, 0);
    foreach (dir_tab[i])
      send_item(dir_tab[i]);
    drain();

    // Widest and flattest viewport, sender and receiver both idling.
    write_reg(CFG_WIDTH, 14'd8192);
    write_reg(CFG_HEIGHT, 14'd1);
    tx_idle = 26;
    rx_idle = 48;
    random_phase(400);
    drain();

    // Narrowest and tallest viewport, idle rates swapped. Halfway through
    // the sender waits until every result is back.
    write_reg(CFG_WIDTH, 14'd1);
    write_reg(CFG_HEIGHT, 14'd8192);
    tx_idle = 48;
    rx_idle = 26;
    random_phase(200);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0)
      @(posedge clk);
    random_phase(200);
    drain();

    // Random viewport, no idling. The receiver holds off for a long stretch
    // while items keep coming, so the block backs up and stalls its input.
    write_reg(CFG_WIDTH, DIM_W'($urandom_range(1, 8192)));
    write_reg(CFG_HEIGHT, DIM_W'($urandom_range(1, 8192)));
    tx_idle = 0;
    rx_idle = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (800) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    random_phase(400);
    drain();

    // A zero width forces the horizontal output to zero.
    write_reg(CFG_WIDTH, 14'd0);
    write_reg(CFG_HEIGHT, DIM_W'($urandom_range(1, 16383)));
    random_phase(430);
    drain();

    if (errors == 0)
      $display("[perspective_point_projector] OK");
    else
      $display("[perspective_point_projector] ERROR");
    $finish;
  end

endmodule
